// File: sv/variable_width_integer_alu_macros.svh
// Assertion macros for the variable width integer ALU.
// Included by the top level; relies on nothing else.
`ifndef VARIABLE_WIDTH_INTEGER_ALU_MACROS_SVH
`define VARIABLE_WIDTH_INTEGER_ALU_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define VWALU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vwalu assertion failed");

// Implication on the default clock and reset names of the block.
`define VWALU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vwalu implication failed");

`endif

// File: sv/vwalu_pkg.sv
// Shared types and constants for the variable width integer ALU.
// Used by every module of the block; depends on nothing.
`default_nettype none
package vwalu_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned KIND_W        = 5;
  localparam int unsigned WID_W         = 7;
  localparam int unsigned DEF_MAX_WIDTH = 64;

  localparam logic [KIND_W-1:0] K_ADD  = 5'd0;
  localparam logic [KIND_W-1:0] K_SUB  = 5'd1;
  localparam logic [KIND_W-1:0] K_MUL  = 5'd2;
  localparam logic [KIND_W-1:0] K_SDIV = 5'd3;
  localparam logic [KIND_W-1:0] K_UDIV = 5'd4;
  localparam logic [KIND_W-1:0] K_SREM = 5'd5;
  localparam logic [KIND_W-1:0] K_SHL  = 5'd6;
  localparam logic [KIND_W-1:0] K_LSHR = 5'd7;
  localparam logic [KIND_W-1:0] K_ASHR = 5'd8;
  localparam logic [KIND_W-1:0] K_AND  = 5'd9;
  localparam logic [KIND_W-1:0] K_OR   = 5'd10;
  localparam logic [KIND_W-1:0] K_XOR  = 5'd11;
  localparam logic [KIND_W-1:0] K_EQ   = 5'd12;
  localparam logic [KIND_W-1:0] K_NE   = 5'd13;
  localparam logic [KIND_W-1:0] K_SLT  = 5'd14;
  localparam logic [KIND_W-1:0] K_SLE  = 5'd15;
  localparam logic [KIND_W-1:0] K_SGT  = 5'd16;
  localparam logic [KIND_W-1:0] K_SGE  = 5'd17;
  localparam logic [KIND_W-1:0] K_ULT  = 5'd18;
  localparam logic [KIND_W-1:0] K_ULE  = 5'd19;
  localparam logic [KIND_W-1:0] K_UGT  = 5'd20;
  localparam logic [KIND_W-1:0] K_UGE  = 5'd21;
  localparam logic [KIND_W-1:0] K_LAND = 5'd22;
  localparam logic [KIND_W-1:0] K_LOR  = 5'd23;

  typedef enum logic [2:0] {
    SEL_SIMPLE,
    SEL_MUL,
    SEL_UDIV,
    SEL_SDIV,
    SEL_SREM
  } res_sel_e;

  typedef struct packed {
    logic             valid;
    logic             ok;
    res_sel_e         sel;
    logic             neg;
    logic [WID_W-1:0] ow;
    logic [WID_W-1:0] rw;
  } ctrl_t;

endpackage
`default_nettype wire

// File: sv/variable_width_integer_alu.sv
// Top level of the variable width integer ALU.
// Instantiates vwalu_front, a chain of vwalu_cell and vwalu_back; uses vwalu_pkg.
//
// Usage: drive kind_i, lhs_i, rhs_i, operand_width_i and result_width_i and
// raise start_i for one cycle per item. busy_o is always low, so an item is
// taken at every rising edge at which start_i is high, one per cycle.
// Each item gives exactly one result: valid_o is high for one cycle with
// folded_o and value_o, in the order the items came in.
// The pipeline has one decode stage, one cell per bit of
// the multiply and divide chain, and one output stage. The chain handles
// one quotient bit and one partial product per cell, so every item runs
// the full length and throughput is one item per cycle.
// Reset clears the valid flags of all stages; items in flight are dropped.
// The receiver cannot stall, and nothing is held back for it.
`default_nettype none
`include "variable_width_integer_alu_macros.svh"
module variable_width_integer_alu #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [vwalu_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [vwalu_pkg::DATA_W-1:0] lhs_i,
  input  logic signed [vwalu_pkg::DATA_W-1:0] rhs_i,
  input  logic [vwalu_pkg::WID_W-1:0]         operand_width_i,
  input  logic [vwalu_pkg::WID_W-1:0]         result_width_i,
  output logic                                valid_o,
  output logic                                folded_o,
  output logic [vwalu_pkg::DATA_W-1:0]        value_o
);
  import vwalu_pkg::*;

  localparam int unsigned DW  = MAX_WIDTH;
  localparam int unsigned LAT = DW + 2;

  ctrl_t         ctrl_c   [0:DW];
  logic [DW-1:0] simple_c [0:DW];
  logic [DW-1:0] acc_c    [0:DW];
  logic [DW-1:0] mcand_c  [0:DW];
  logic [DW-1:0] mplier_c [0:DW];
  logic [DW-1:0] num_c    [0:DW];
  logic [DW-1:0] den_c    [0:DW];
  logic [DW-1:0] rem_c    [0:DW];
  logic [DW-1:0] quo_c    [0:DW];

  assign busy_o   = 1'b0;
  assign acc_c[0] = '0;
  assign rem_c[0] = '0;
  assign quo_c[0] = '0;

  vwalu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (start_i && !busy_o),
    .kind_i         (kind_i),
    .lhs_i          (lhs_i),
    .rhs_i          (rhs_i),
    .operand_width_i(operand_width_i),
    .result_width_i (result_width_i),
    .ctrl_o         (ctrl_c[0]),
    .simple_o       (simple_c[0]),
    .mcand_o        (mcand_c[0]),
    .mplier_o       (mplier_c[0]),
    .num_o          (num_c[0]),
    .den_o          (den_c[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    vwalu_cell #(.MAX_WIDTH(MAX_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_c[i]),
      .simple_i(simple_c[i]),
      .acc_i   (acc_c[i]),
      .mcand_i (mcand_c[i]),
      .mplier_i(mplier_c[i]),
      .num_i   (num_c[i]),
      .den_i   (den_c[i]),
      .rem_i   (rem_c[i]),
      .quo_i   (quo_c[i]),
      .ctrl_o  (ctrl_c[i+1]),
      .simple_o(simple_c[i+1]),
      .acc_o   (acc_c[i+1]),
      .mcand_o (mcand_c[i+1]),
      .mplier_o(mplier_c[i+1]),
      .num_o   (num_c[i+1]),
      .den_o   (den_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .quo_o   (quo_c[i+1])
    );
  end

  vwalu_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_c[DW]),
    .simple_i(simple_c[DW]),
    .acc_i   (acc_c[DW]),
    .rem_i   (rem_c[DW]),
    .quo_i   (quo_c[DW]),
    .valid_o (valid_o),
    .folded_o(folded_o),
    .value_o (value_o)
  );

  `VWALU_ASSERT_IMP(a_latency, valid_o, $past(start_i, LAT))
  `VWALU_ASSERT_IMP(a_unfolded_zero, valid_o && !folded_o, value_o == '0)
  `VWALU_ASSERT(a_bad_width, clk_i, rst_ni,
    (valid_o && ($past(operand_width_i, LAT) == '0)) |-> !folded_o)

endmodule
`default_nettype wire

// File: sv/vwalu_front.sv
// Input stage: decodes an item, computes the simple operations and
// prepares the operands for the multiply and divide cells. Uses vwalu_pkg.
`default_nettype none
module vwalu_front #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::DEF_MAX_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [vwalu_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [vwalu_pkg::DATA_W-1:0] lhs_i,
  input  logic signed [vwalu_pkg::DATA_W-1:0] rhs_i,
  input  logic [vwalu_pkg::WID_W-1:0]        operand_width_i,
  input  logic [vwalu_pkg::WID_W-1:0]        result_width_i,
  output vwalu_pkg::ctrl_t                   ctrl_o,
  output logic [MAX_WIDTH-1:0]               simple_o,
  output logic [MAX_WIDTH-1:0]               mcand_o,
  output logic [MAX_WIDTH-1:0]               mplier_o,
  output logic [MAX_WIDTH-1:0]               num_o,
  output logic [MAX_WIDTH-1:0]               den_o
);
  import vwalu_pkg::*;

  localparam int unsigned DW = MAX_WIDTH;
  localparam int unsigned SW = $clog2(DW);

  logic [DW-1:0] om, hb, a, b, sa, sb, abs_a, abs_b, simple;
  logic [DW-1:0] num, den;
  logic [SW-1:0] amt;
  logic          wid_ok, bad_sh, ok, neg;
  res_sel_e      sel;
  ctrl_t         ctrl_d, ctrl_q;
  logic [DW-1:0] simple_q, mcand_q, mplier_q, num_q, den_q;

  assign om     = ~({DW{1'b1}} << operand_width_i);
  assign hb     = om ^ (om >> 1);
  assign a      = lhs_i[DW-1:0] & om;
  assign b      = rhs_i[DW-1:0] & om;
  assign sa     = a | ((|(a & hb)) ? ~om : '0);
  assign sb     = b | ((|(b & hb)) ? ~om : '0);
  assign abs_a  = sa[DW-1] ? -sa : sa;
  assign abs_b  = sb[DW-1] ? -sb : sb;
  assign amt    = rhs_i[SW-1:0];
  assign bad_sh = rhs_i[DATA_W-1] || ($unsigned(rhs_i) >= DATA_W'(operand_width_i));
  assign wid_ok = (operand_width_i != '0) && (operand_width_i <= WID_W'(DW)) &&
                  (result_width_i != '0) && (result_width_i <= WID_W'(DW));

  always_comb begin
    ok     = 1'b1;
    sel    = SEL_SIMPLE;
    neg    = 1'b0;
    simple = '0;
    num    = abs_a;
    den    = abs_b;
    case (kind_i)
      K_ADD: simple = a + b;
      K_SUB: simple = a - b;
      K_MUL: sel = SEL_MUL;
      K_SDIV: begin
        sel = SEL_SDIV;
        neg = sa[DW-1] ^ sb[DW-1];
        ok  = (b != '0) && !((a == hb) && (b == om));
      end
      K_UDIV: begin
        sel = SEL_UDIV;
        num = a;
        den = b;
        ok  = (b != '0);
      end
      K_SREM: begin
        sel = SEL_SREM;
        neg = sa[DW-1];
        ok  = (b != '0);
      end
      K_SHL: begin
        simple = a << amt;
        ok     = !bad_sh;
      end
      K_LSHR: begin
        simple = a >> amt;
        ok     = !bad_sh;
      end
      K_ASHR: begin
        simple = $unsigned($signed(sa) >>> amt);
        ok     = !bad_sh;
      end
      K_AND:  simple = a & b;
      K_OR:   simple = a | b;
      K_XOR:  simple = a ^ b;
      K_EQ:   simple = DW'(a == b);
      K_NE:   simple = DW'(a != b);
      K_SLT:  simple = DW'($signed(sa) <  $signed(sb));
      K_SLE:  simple = DW'($signed(sa) <= $signed(sb));
      K_SGT:  simple = DW'($signed(sa) >  $signed(sb));
      K_SGE:  simple = DW'($signed(sa) >= $signed(sb));
      K_ULT:  simple = DW'(a <  b);
      K_ULE:  simple = DW'(a <= b);
      K_UGT:  simple = DW'(a >  b);
      K_UGE:  simple = DW'(a >= b);
      K_LAND: simple = DW'((lhs_i != '0) && (rhs_i != '0));
      K_LOR:  simple = DW'((lhs_i != '0) || (rhs_i != '0));
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    ctrl_d       = '0;
    ctrl_d.valid = in_valid_i;
    ctrl_d.ok    = ok && wid_ok;
    ctrl_d.sel   = sel;
    ctrl_d.neg   = neg;
    ctrl_d.ow    = operand_width_i;
    ctrl_d.rw    = result_width_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    simple_q <= simple;
    mcand_q  <= a;
    mplier_q <= b;
    num_q    <= num;
    den_q    <= den;
  end

  assign ctrl_o   = ctrl_q;
  assign simple_o = simple_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
  assign num_o    = num_q;
  assign den_o    = den_q;

endmodule
`default_nettype wire

// File: sv/vwalu_cell.sv
// One cell of the arithmetic chain: a shift-add multiply step and a
// restoring divide step per cycle, handed to the next cell. Uses vwalu_pkg.
`default_nettype none
module vwalu_cell #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::DEF_MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vwalu_pkg::ctrl_t     ctrl_i,
  input  logic [MAX_WIDTH-1:0] simple_i,
  input  logic [MAX_WIDTH-1:0] acc_i,
  input  logic [MAX_WIDTH-1:0] mcand_i,
  input  logic [MAX_WIDTH-1:0] mplier_i,
  input  logic [MAX_WIDTH-1:0] num_i,
  input  logic [MAX_WIDTH-1:0] den_i,
  input  logic [MAX_WIDTH-1:0] rem_i,
  input  logic [MAX_WIDTH-1:0] quo_i,
  output vwalu_pkg::ctrl_t     ctrl_o,
  output logic [MAX_WIDTH-1:0] simple_o,
  output logic [MAX_WIDTH-1:0] acc_o,
  output logic [MAX_WIDTH-1:0] mcand_o,
  output logic [MAX_WIDTH-1:0] mplier_o,
  output logic [MAX_WIDTH-1:0] num_o,
  output logic [MAX_WIDTH-1:0] den_o,
  output logic [MAX_WIDTH-1:0] rem_o,
  output logic [MAX_WIDTH-1:0] quo_o
);
  import vwalu_pkg::*;

  localparam int unsigned DW = MAX_WIDTH;

  logic [DW:0]   rem_sh, rem_sub;
  logic          qbit;
  ctrl_t         ctrl_q;
  logic [DW-1:0] simple_q, acc_q, mcand_q, mplier_q, num_q, den_q, rem_q, quo_q;
  logic [DW-1:0] acc_d, rem_d;

  assign rem_sh  = {rem_i, num_i[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den_i};
  assign qbit    = !rem_sub[DW];
  assign rem_d   = qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
  assign acc_d   = acc_i + (mplier_i[0] ? mcand_i : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    simple_q <= simple_i;
    acc_q    <= acc_d;
    mcand_q  <= mcand_i << 1;
    mplier_q <= mplier_i >> 1;
    num_q    <= num_i << 1;
    den_q    <= den_i;
    rem_q    <= rem_d;
    quo_q    <= {quo_i[DW-2:0], qbit};
  end

  assign ctrl_o   = ctrl_q;
  assign simple_o = simple_q;
  assign acc_o    = acc_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
  assign num_o    = num_q;
  assign den_o    = den_q;
  assign rem_o    = rem_q;
  assign quo_o    = quo_q;

endmodule
`default_nettype wire

// File: sv/vwalu_back.sv
// Output stage: selects the result, applies signs, extends or truncates
// to the result width and registers the strobed result. Uses vwalu_pkg.
`default_nettype none
module vwalu_back #(
  parameter int unsigned MAX_WIDTH = vwalu_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vwalu_pkg::ctrl_t            ctrl_i,
  input  logic [MAX_WIDTH-1:0]        simple_i,
  input  logic [MAX_WIDTH-1:0]        acc_i,
  input  logic [MAX_WIDTH-1:0]        rem_i,
  input  logic [MAX_WIDTH-1:0]        quo_i,
  output logic                        valid_o,
  output logic                        folded_o,
  output logic [vwalu_pkg::DATA_W-1:0] value_o
);
  import vwalu_pkg::*;

  localparam int unsigned DW = MAX_WIDTH;

  logic [DW-1:0]     om, rm, hb, res, ext;
  logic              valid_q, folded_q;
  logic [DATA_W-1:0] value_q, value_d;

  assign om = ~({DW{1'b1}} << ctrl_i.ow);
  assign rm = ~({DW{1'b1}} << ctrl_i.rw);
  assign hb = om ^ (om >> 1);

  always_comb begin
    case (ctrl_i.sel)
      SEL_MUL:  res = acc_i;
      SEL_UDIV: res = quo_i;
      SEL_SDIV: res = ctrl_i.neg ? -quo_i : quo_i;
      SEL_SREM: res = ctrl_i.neg ? -rem_i : rem_i;
      default:  res = simple_i;
    endcase
  end

  assign ext     = (res & om) | ((|(res & hb)) ? ~om : '0);
  assign value_d = ctrl_i.ok ? DATA_W'(ext & rm) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    folded_q <= ctrl_i.ok;
    value_q  <= value_d;
  end

  assign valid_o  = valid_q;
  assign folded_o = folded_q;
  assign value_o  = value_q;

endmodule
`default_nettype wire
